FILE: hdl/rilp_pkg.sv
// ----------------------------------------------------------------------------
// rilp_pkg
// Types and character constants for the radix integer literal parser.
// ----------------------------------------------------------------------------
package rilp_pkg;

   // Input transfer: one character of an atom
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   // Result transfer: one parsed atom
   typedef struct packed {
      logic               is_number;
      logic signed [63:0] number_value;
   } rsp_payload_type;

   // Parse phases
   typedef enum logic [1:0] {
      PH_SIGN   = 2'd0,
      PH_ZERO   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_STOP   = 2'd3
   } phase_type;

   // Radix codes (the base itself)
   localparam logic [4:0] BASE_NONE = 5'd0;
   localparam logic [4:0] BASE_BIN  = 5'd2;
   localparam logic [4:0] BASE_OCT  = 5'd8;
   localparam logic [4:0] BASE_DEC  = 5'd10;
   localparam logic [4:0] BASE_DOZ  = 5'd12;
   localparam logic [4:0] BASE_HEX  = 5'd16;

   // Digit value that marks a non-digit character
   localparam logic [4:0] DIGIT_NONE = 5'd16;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_O  = 8'h6F;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

endpackage

FILE: hdl/radix_integer_literal_parser_top.sv
// ----------------------------------------------------------------------------
// radix_integer_literal_parser_top
// Parses one atom, one character per transfer, into a signed integer with
// optional sign characters and a radix prefix (0b 0o 0d 0z 0x).
//
//   channel  ports        payload            dir  transfer
//   req      req_*        req_payload_type   in   one character, last flagged
//   rsp      rsp_*        rsp_payload_type   out  one result per atom
//
// One character per cycle, except that a last character waits while the
// result register is full and not being taken, and holds back those
// behind it. A character is registered in the input register; the parser
// state and, for a last character, the result register update from it.
// The shift-add of accumulator times base plus digit sets the cycle time.
// reset clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
module radix_integer_literal_parser_top #(
   parameter int VALUE_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rilp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rilp_pkg::rsp_payload_type rsp_payload
);
   import rilp_pkg::*;

   // Input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // Parser state
   phase_type               phase_ff,  phase_in;
   logic                    neg_ff,    neg_in;
   logic [4:0]              base_ff,   base_in;
   logic [VALUE_BITS-1:0]   acc_ff,    acc_in;
   logic                    seen_ff,   seen_in;
   logic                    failed_ff, failed_in;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                  rsp_free;
   logic                  proc_fire;
   logic                  emit;
   logic [7:0]            ch;
   logic [7:0]            ch_fold;
   logic [4:0]            digit;
   logic [4:0]            radix;
   logic                  digit_bad;
   logic [VALUE_BITS-1:0] acc_scaled;
   logic [VALUE_BITS-1:0] acc_digit;
   logic [VALUE_BITS-1:0] value_signed;

   // Handshake control
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && (!in_data_ff.last_char || rsp_free);
   assign emit      = proc_fire && in_data_ff.last_char;
   assign req_ready = !in_valid_ff || proc_fire;

   // Capture the incoming character
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // Fold case and decode the character
   always_comb begin
      ch = in_data_ff.char_code;
      if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
         ch_fold = ch + CASE_GAP;
      end else begin
         ch_fold = ch;
      end

      if (ch_fold >= CH_0 && ch_fold <= CH_9) begin
         digit = 5'(ch_fold - CH_0);
      end else if (ch_fold >= CH_LO_A && ch_fold <= CH_LO_F) begin
         digit = 5'(ch_fold - CH_LO_A + 8'd10);
      end else begin
         digit = DIGIT_NONE;
      end

      case (ch_fold)
         CH_LO_B: radix = BASE_BIN;
         CH_LO_O: radix = BASE_OCT;
         CH_LO_D: radix = BASE_DEC;
         CH_LO_Z: radix = BASE_DOZ;
         CH_LO_X: radix = BASE_HEX;
         default: radix = BASE_NONE;
      endcase
   end

   // Multiply by the base as a shift-add, then add the digit
   always_comb begin
      case (base_ff)
         BASE_BIN: acc_scaled = acc_ff << 1;
         BASE_OCT: acc_scaled = acc_ff << 3;
         BASE_DEC: acc_scaled = (acc_ff << 3) + (acc_ff << 1);
         BASE_DOZ: acc_scaled = (acc_ff << 3) + (acc_ff << 2);
         BASE_HEX: acc_scaled = acc_ff << 4;
         default:  acc_scaled = '0;
      endcase
      acc_digit = acc_scaled + VALUE_BITS'(digit);
      digit_bad = (digit >= base_ff);
   end

   // Next state of the parser
   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;

      if (ch == CH_NUL) begin
         phase_in = PH_STOP;
      end else if (!failed_ff) begin
         case (phase_ff)
            PH_SIGN: begin
               if (ch == CH_MINUS) begin
                  neg_in = !neg_ff;
               end else if (ch == CH_PLUS) begin
                  neg_in = neg_ff;
               end else if (ch == CH_0) begin
                  base_in  = BASE_DEC;
                  acc_in   = '0;
                  seen_in  = 1'b1;
                  phase_in = PH_ZERO;
               end else begin
                  phase_in = PH_DIGITS;
                  if (digit_bad) begin
                     failed_in = 1'b1;
                  end else begin
                     acc_in  = acc_digit;
                     seen_in = 1'b1;
                  end
               end
            end
            PH_ZERO: begin
               phase_in = PH_DIGITS;
               if (radix != BASE_NONE) begin
                  base_in = radix;
                  acc_in  = '0;
                  seen_in = 1'b0;
               end else if (digit_bad) begin
                  failed_in = 1'b1;
               end else begin
                  acc_in  = acc_digit;
                  seen_in = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (digit_bad) begin
                  failed_in = 1'b1;
               end else begin
                  acc_in  = acc_digit;
                  seen_in = 1'b1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result of the atom, formed from the updated state
   always_comb begin
      value_signed = neg_in ? (VALUE_BITS'(0) - acc_in) : acc_in;
      rsp_data_in.is_number = seen_in && !failed_in;
      if (seen_in && !failed_in) begin
         rsp_data_in.number_value = 64'(signed'(value_signed));
      end else begin
         rsp_data_in.number_value = '0;
      end
   end

   // Advance the parser; return to the start state after the last character
   always_ff @(posedge clock) begin
      if (reset || emit) begin
         phase_ff  <= PH_SIGN;
         neg_ff    <= 1'b0;
         base_ff   <= BASE_DEC;
         acc_ff    <= '0;
         seen_ff   <= 1'b0;
         failed_ff <= 1'b0;
      end else if (proc_fire) begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         base_ff   <= base_in;
         acc_ff    <= acc_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Checks
   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.is_number || rsp_data_ff.number_value == 64'sd0))
      else $error("symbol result carries a nonzero value");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_restart_after_atom: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_SIGN && !neg_ff && !seen_ff && !failed_ff
                && base_ff == BASE_DEC))
      else $error("parser state not restarted after last character");

   a_base_legal: assert property (@(posedge clock) disable iff (reset)
      (base_ff == BASE_BIN || base_ff == BASE_OCT || base_ff == BASE_DEC
       || base_ff == BASE_DOZ || base_ff == BASE_HEX))
      else $error("illegal radix in parser state");

endmodule

FILE: tb/rilp_result_checker.sv
// ----------------------------------------------------------------------------
// rilp_result_checker
// Watches both channels of the radix integer literal parser. It parses every
// accepted character with its own copy of the parser state, queues the
// result that each last character must produce, and compares every result
// transfer field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module rilp_result_checker #(
   parameter int VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  rilp_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rilp_pkg::rsp_payload_type rsp_payload,
   output int                        mismatches,
   output int                        pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import rilp_pkg::*;

   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

   // Parser state of the prediction
   phase_type   parse_phase;
   logic        negate;
   logic [4:0]  base;
   logic [63:0] acc;
   logic        seen;
   logic        failed;

   // Results still owed by the block, oldest first
   rsp_payload_type awaited_atoms[$];

   function automatic void clear_parser();
      parse_phase = PH_SIGN;
      negate      = 1'b0;
      base        = BASE_DEC;
      acc         = '0;
      seen        = 1'b0;
      failed      = 1'b0;
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
   endfunction

   // Accumulate one digit, or mark the atom as a symbol
   function automatic void take_digit(input logic [7:0] c);
      logic [7:0] f;
      logic [4:0] d;
      f = fold_case(c);
      if (f >= CH_0 && f <= CH_9) begin
         d = 5'(f - CH_0);
      end else if (f >= CH_LO_A && f <= CH_LO_F) begin
         d = 5'(f - CH_LO_A) + 5'd10;
      end else begin
         d = DIGIT_NONE;
      end
      if (d >= base) begin
         failed = 1'b1;
      end else begin
         acc  = (acc * 64'(base) + 64'(d)) & VALUE_MASK;
         seen = 1'b1;
      end
   endfunction

   // Advance the parser by one character; produce a result on the last one
   function automatic void parse_char(input req_payload_type item,
                                      output logic produced,
                                      output rsp_payload_type outcome);
      logic [7:0]  c;
      logic [4:0]  radix;
      logic [63:0] v;
      logic        ok;
      c = item.char_code;
      if (c == CH_NUL) begin
         parse_phase = PH_STOP;
      end else if (!failed) begin
         case (parse_phase)
            PH_SIGN: begin
               if (c == CH_MINUS) begin
                  negate = ~negate;
               end else if (c == CH_0) begin
                  base        = BASE_DEC;
                  acc         = '0;
                  seen        = 1'b1;
                  parse_phase = PH_ZERO;
               end else if (c != CH_PLUS) begin
                  parse_phase = PH_DIGITS;
                  take_digit(c);
               end
            end
            PH_ZERO: begin
               case (fold_case(c))
                  CH_LO_B: radix = BASE_BIN;
                  CH_LO_O: radix = BASE_OCT;
                  CH_LO_D: radix = BASE_DEC;
                  CH_LO_Z: radix = BASE_DOZ;
                  CH_LO_X: radix = BASE_HEX;
                  default: radix = BASE_NONE;
               endcase
               parse_phase = PH_DIGITS;
               if (radix != BASE_NONE) begin
                  base = radix;
                  acc  = '0;
                  seen = 1'b0;
               end else begin
                  take_digit(c);
               end
            end
            PH_DIGITS: take_digit(c);
            default: ;
         endcase
      end

      produced = item.last_char;
      outcome  = '0;
      if (item.last_char) begin
         ok = seen && !failed;
         v  = '0;
         if (ok) begin
            v = negate ? ((~acc + 64'd1) & VALUE_MASK) : (acc & VALUE_MASK);
            if (v[VALUE_BITS-1]) v = v | ~VALUE_MASK;
         end
         outcome.is_number    = ok;
         outcome.number_value = v;
         clear_parser();
      end
   endfunction

   task automatic flag_mismatch(input string what, input rsp_payload_type want,
                                input rsp_payload_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected is_number=%0b value=%0d, got is_number=%0b value=%0d",
                  $realtime, what, want.is_number, want.number_value,
                  got.is_number, got.number_value);
      end
   endtask

   // Check result transfers, then predict from character transfers
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type outcome;
      logic            produced;
      if (reset) begin
         clear_parser();
         awaited_atoms.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_atoms.size() == 0) begin
               flag_mismatch("result with none awaited", '0, rsp_payload);
            end else begin
               want = awaited_atoms.pop_front();
               if (want.is_number !== rsp_payload.is_number ||
                   want.number_value !== rsp_payload.number_value) begin
                  flag_mismatch("result mismatch", want, rsp_payload);
               end
            end
         end
         if (req_valid && req_ready) begin
            parse_char(req_payload, produced, outcome);
            if (produced) awaited_atoms.push_back(outcome);
         end
      end
      pending_results <= awaited_atoms.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the radix integer literal parser with atoms, one character per
// transfer: a short directed set for prefixes, signs, bad digits and NUL
// bytes, then random atoms, mostly well formed with random digits and some
// noise. Both sides idle at random; the receiver also holds off for a long
// stretch. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rilp_pkg::*;

   localparam int VALUE_BITS   = 64;
   localparam int ITEM_TARGET  = 1700;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 100000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int              mismatches;
   int              pending_results;
   int              cycle_count = 0;
   int              items_sent = 0;
   bit              steady = 1'b0;
   bit              hold_off = 1'b0;
   logic [7:0]      atom_text[$];

   always #2 clock = ~clock;

   radix_integer_literal_parser_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   rilp_result_checker #(
      .VALUE_BITS(VALUE_BITS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatches     (mismatches),
      .pending_results(pending_results)
   );

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: random idling, a steady stretch, one long hold-off
   always begin
      @(posedge clock);
      if (hold_off) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_off = 1'b0;
      end
      rsp_ready <= steady || ($urandom_range(99) >= 27);
   end

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) atom_text.push_back(s[i]);
   endfunction

   // Send the queued atom, last character flagged, then clear it
   task automatic send_atom();
      req_payload_type next_char;
      foreach (atom_text[i]) begin
         while (!steady && $urandom_range(99) < 27) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         next_char.char_code = atom_text[i];
         next_char.last_char = (i == atom_text.size() - 1);
         req_valid   <= 1'b1;
         req_payload <= next_char;
         do @(posedge clock); while (!req_ready);
         items_sent++;
      end
      atom_text.delete();
   endtask

   // Drop valid and hold until every owed result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   // Build one random atom: signs, optional radix prefix, digits, damage
   task automatic build_random_atom();
      int unsigned kind;
      int unsigned roll;
      int unsigned n;
      int unsigned d;
      logic [4:0]  base;
      logic [7:0]  ch;
      kind = $urandom_range(99);
      atom_text.delete();
      if (kind < 12) begin
         // pure noise
         n = $urandom_range(1, 6);
         repeat (n) atom_text.push_back(8'($urandom_range(255)));
         return;
      end

      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) atom_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);

      base = BASE_DEC;
      case ($urandom_range(5))
         0: begin base = BASE_BIN; ch = CH_LO_B; end
         1: begin base = BASE_OCT; ch = CH_LO_O; end
         2: begin base = BASE_DEC; ch = CH_LO_D; end
         3: begin base = BASE_DOZ; ch = CH_LO_Z; end
         4: begin base = BASE_HEX; ch = CH_LO_X; end
         default: ch = CH_NUL;
      endcase
      if (ch != CH_NUL) begin
         atom_text.push_back(CH_0);
         atom_text.push_back($urandom_range(1) ? ch - CASE_GAP : ch);
      end

      // a few long digit runs to wrap the value
      roll = $urandom_range(99);
      if (roll < 5) n = 0;
      else if (roll < 15) n = $urandom_range(16, 26);
      else n = $urandom_range(1, 8);
      repeat (n) begin
         d = $urandom_range(int'(base) - 1);
         if (d < 10) begin
            ch = CH_0 + 8'(d);
         end else begin
            ch = CH_LO_A + 8'(d - 10);
            if ($urandom_range(1)) ch = ch - CASE_GAP;
         end
         atom_text.push_back(ch);
      end

      // damage some atoms with a NUL or a random byte
      if (kind < 25) begin
         ch = $urandom_range(1) ? CH_NUL : 8'($urandom_range(255));
         atom_text.insert($urandom_range(atom_text.size()), ch);
      end
      if (atom_text.size() == 0) atom_text.push_back(CH_MINUS);
   endtask

   initial begin
      int atom_index;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lone zero, each radix, signs, empty digits, bad digit, NUL
      add_text("0");     send_atom();
      add_text("-0o7");  send_atom();
      add_text("0zB");   send_atom();
      add_text("+0XfF"); send_atom();
      add_text("+-");    send_atom();
      add_text("0D");    send_atom();
      add_text("0b2");   send_atom();
      atom_text = '{8'h39, CH_NUL, 8'hFF};
      send_atom();
      add_text("07");    send_atom();

      // Random atoms with a steady stretch, a receiver hold-off and a drain
      atom_index = 0;
      while (items_sent < ITEM_TARGET) begin
         if (atom_index == 60) steady = 1'b1;
         if (atom_index == 100) steady = 1'b0;
         if (atom_index == 130) hold_off = 1'b1;
         if (atom_index == 170) drain_results();
         build_random_atom();
         send_atom();
         atom_index++;
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_results == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
